@@ sv/egcd_pkg.sv @@
// Package for the extended Euclid gcd block.
// Holds the default operand width and the controller/datapath command and status types.
// No dependencies.
package egcd_pkg;

	localparam int OPERAND_BITS_DEF = 31;

	typedef struct packed {
		logic load;
		logic start_q;
		logic align;
		logic sub;
		logic update;
		logic capture;
	} egcd_cmd_t;

	typedef struct packed {
		logic align_ok;
		logic last;
		logic r1_zero;
		logic err;
	} egcd_status_t;

endpackage

@@ sv/egcd_if.sv @@
// Valid/ready channel interfaces for the extended Euclid gcd block.
// egcd_in_if carries the operand pair, egcd_out_if the gcd and coefficients.
// No dependencies.
interface egcd_in_if #(
	parameter int OPERAND_BITS = 31
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] operand_a;
	logic [OPERAND_BITS-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if #(
	parameter int OPERAND_BITS = 31
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] divisor_out;
	logic signed [OPERAND_BITS:0] coef_a;
	logic signed [OPERAND_BITS:0] coef_b;
	logic                    order_error;

	modport source (output valid, output divisor_out, output coef_a, output coef_b,
		output order_error, input ready);
	modport sink   (input valid, input divisor_out, input coef_a, input coef_b,
		input order_error, output ready);
endinterface

@@ sv/egcd_dp.sv @@
// Datapath of the extended Euclid gcd block: remainder pair, coefficient pairs,
// shift-subtract quotient unit with Horner accumulation of q*s and q*t, result register.
// Depends on egcd_pkg.
module egcd_dp import egcd_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                         clk,
	input  egcd_cmd_t                    cmd,
	output egcd_status_t                 sts,
	input  logic [OPERAND_BITS-1:0]      operand_a,
	input  logic [OPERAND_BITS-1:0]      operand_b,
	output logic [OPERAND_BITS-1:0]      divisor_out,
	output logic signed [OPERAND_BITS:0] coef_a,
	output logic signed [OPERAND_BITS:0] coef_b,
	output logic                         order_error
);
	localparam int W  = OPERAND_BITS;
	localparam int C  = OPERAND_BITS + 1;
	localparam int KW = $clog2(OPERAND_BITS);

	logic [W-1:0]  r0_q, r1_q, rem_q, dv_q;
	logic [C-1:0]  s0_q, s1_q, t0_q, t1_q, acc_s_q, acc_t_q;
	logic [KW-1:0] k_q;
	logic          err_q;
	logic          take;

	logic [W-1:0]  div_q;
	logic [C-1:0]  ca_q, cb_q;
	logic          oe_q;

	assign take         = dv_q <= rem_q;
	assign sts.align_ok = {dv_q, 1'b0} <= {1'b0, rem_q};
	assign sts.last     = k_q == '0;
	assign sts.r1_zero  = r1_q == '0;
	assign sts.err      = err_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q  <= operand_a;
			r1_q  <= operand_b;
			s0_q  <= C'(1);
			s1_q  <= '0;
			t0_q  <= '0;
			t1_q  <= C'(1);
			err_q <= operand_a < operand_b;
		end
		if (cmd.start_q) begin
			rem_q   <= r0_q;
			dv_q    <= r1_q;
			k_q     <= '0;
			acc_s_q <= '0;
			acc_t_q <= '0;
		end
		if (cmd.align) begin
			dv_q <= {dv_q[W-2:0], 1'b0};
			k_q  <= k_q + KW'(1);
		end
		if (cmd.sub) begin
			if (take) begin
				rem_q <= rem_q - dv_q;
			end
			acc_s_q <= {acc_s_q[C-2:0], 1'b0} + (take ? s1_q : '0);
			acc_t_q <= {acc_t_q[C-2:0], 1'b0} + (take ? t1_q : '0);
			dv_q    <= {1'b0, dv_q[W-1:1]};
			k_q     <= k_q - KW'(1);
		end
		if (cmd.update) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
			s0_q <= s1_q;
			s1_q <= s0_q - acc_s_q;
			t0_q <= t1_q;
			t1_q <= t0_q - acc_t_q;
		end
		if (cmd.capture) begin
			div_q <= r0_q;
			ca_q  <= s0_q;
			cb_q  <= t0_q;
			oe_q  <= err_q;
		end
	end

	assign divisor_out = div_q;
	assign coef_a      = signed'(ca_q);
	assign coef_b      = signed'(cb_q);
	assign order_error = oe_q;
endmodule

@@ sv/egcd_ctrl.sv @@
// Controller of the extended Euclid gcd block: sequences load, quotient alignment,
// shift-subtract steps, remainder update and result capture; owns the handshakes.
// Depends on egcd_pkg.
module egcd_ctrl import egcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output egcd_cmd_t    cmd,
	input  egcd_status_t sts
);
	typedef enum logic [2:0] {IDLE, TEST, ALIGN, SUB, UPDATE, DONE} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE:   cmd.load    = in_valid;
			TEST:   cmd.start_q = !(sts.err || sts.r1_zero);
			ALIGN:  cmd.align   = sts.align_ok;
			SUB:    cmd.sub     = 1'b1;
			UPDATE: cmd.update  = 1'b1;
			DONE:   cmd.capture = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) state_q <= TEST;
				end
				TEST: begin
					state_q <= (sts.err || sts.r1_zero) ? DONE : ALIGN;
				end
				ALIGN: begin
					if (!sts.align_ok) state_q <= SUB;
				end
				SUB: begin
					if (sts.last) state_q <= UPDATE;
				end
				UPDATE: begin
					state_q <= TEST;
				end
				DONE: begin
					if (cmd.capture) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == IDLE;
	assign out_valid = out_valid_q;
endmodule

@@ sv/extended_euclid_gcd.sv @@
// Extended Euclid gcd: d = gcd(a, b) and coefficients s, t with d = s*a + t*b.
// Each quotient q is computed in the single shift-subtract unit; special cases
// (a < b, which sets order_error, or b = 0) go straight to the result.
// One item in flight; the next is accepted the cycle after its result enters the
// output register, which holds while the sink stalls.
// Reset clears the controller and the output valid flag; no data state is kept.
module extended_euclid_gcd import egcd_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	egcd_in_if.sink    in_ch,
	egcd_out_if.source out_ch
);
	egcd_cmd_t    cmd;
	egcd_status_t sts;

	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	egcd_dp #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.operand_a   (in_ch.operand_a),
		.operand_b   (in_ch.operand_b),
		.divisor_out (out_ch.divisor_out),
		.coef_a      (out_ch.coef_a),
		.coef_b      (out_ch.coef_b),
		.order_error (out_ch.order_error)
	);
endmodule
